// File: design/lbmc_pkg.sv
// Shared types, codes and constants for the LED breathing mode controller.
package lbmc_pkg;

  localparam int unsigned ELAPSED_BITS = 17;
  localparam int unsigned INTERVAL_BITS = 16;
  // Width used to compare an elapsed count against an interval.
  localparam int unsigned CMP_BITS =
    (ELAPSED_BITS > INTERVAL_BITS) ? ELAPSED_BITS : INTERVAL_BITS;
  localparam int unsigned FADE_BITS = 10;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_ON    = 3'd1,
    OP_OFF   = 3'd2,
    OP_BLINK = 3'd3,
    OP_PULSE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_ON          = 3'd1,
    MODE_OFF         = 3'd2,
    MODE_BLINK       = 3'd3,
    MODE_BLINK_PULSE = 3'd4,
    MODE_PULSE       = 3'd5
  } mode_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_HIGH_BRIGHTNESS = 3'd0,
    CFG_LOW_BRIGHTNESS  = 3'd1,
    CFG_FADE_STEP       = 3'd2,
    CFG_BLINK_INTERVAL  = 3'd3,
    CFG_PULSE_INTERVAL  = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [2:0] op;
    logic       normal;
  } in_t;

  typedef struct packed {
    logic [7:0] led_level;
    logic       level_written;
    logic [2:0] mode;
  } out_t;

  typedef struct packed {
    logic [7:0]               high_brightness;
    logic [7:0]               low_brightness;
    logic [6:0]               fade_step;
    logic [INTERVAL_BITS-1:0] blink_interval_ms;
    logic [INTERVAL_BITS-1:0] pulse_interval_ms;
  } cfg_t;

  typedef struct packed {
    mode_e                        mode;
    logic signed [FADE_BITS-1:0]  fade_level;
    logic                         fade_down;
    logic [ELAPSED_BITS-1:0]      blink_elapsed;
    logic [ELAPSED_BITS-1:0]      pulse_elapsed;
    logic [7:0]                   pin_level;
  } state_t;

endpackage

// File: design/led_breathing_mode_controller.sv
// Top level: LED breathing mode controller with config registers and result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one beat per
//   item: a 1 ms tick (op 0) or a command (on, off, timed blink, pulse) with
//   a normal/inverted flag. Every accepted beat yields exactly one result
//   beat on the output channel (out_valid_o / out_stall_i / out_data_o):
//   the LED level, whether this beat wrote it, and the mode afterwards.
//   Latency: the result is registered and appears in the cycle after the input beat is accepted.
//   Throughput: one beat per cycle while the output is not stalled. The whole
//   update (saturating counter increments, interval compares, one fade add and
//   the mode decode) sits between the state registers and the single result register.
//   Stall: the result register holds its beat while out_stall_i is high;
//   in_stall_o rises only when that register is full and stalled, so a new
//   beat is taken in the same cycle the waiting result leaves.
//   Config: cfg_valid_i / cfg_ready_o write one register per beat, index as
//   listed (high, low, step, blink interval, pulse interval); other indexes
//   are dropped. Write only while the block is idle. cfg_ready_o is always 1.
//   Reset (rst_ni low, async): registers take their default values, mode
//   goes idle, counters, fade level and LED level clear, output empties.
module led_breathing_mode_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lbmc_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output lbmc_pkg::out_t                       out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lbmc_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [lbmc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  lbmc_pkg::cfg_t   cfg_q;
  lbmc_pkg::state_t st_q, st_d;
  lbmc_pkg::out_t   res_d, res_q;
  logic             out_valid_q;
  logic             in_acc, out_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // configuration register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_brightness   <= 8'd255;
      cfg_q.low_brightness    <= 8'd0;
      cfg_q.fade_step         <= 7'd5;
      cfg_q.blink_interval_ms <= 16'd500;
      cfg_q.pulse_interval_ms <= 16'd30;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lbmc_pkg::cfg_index_e'(cfg_index_i))
        lbmc_pkg::CFG_HIGH_BRIGHTNESS: cfg_q.high_brightness   <= cfg_data_i[7:0];
        lbmc_pkg::CFG_LOW_BRIGHTNESS:  cfg_q.low_brightness    <= cfg_data_i[7:0];
        lbmc_pkg::CFG_FADE_STEP:       cfg_q.fade_step         <= cfg_data_i[6:0];
        lbmc_pkg::CFG_BLINK_INTERVAL:  cfg_q.blink_interval_ms <= cfg_data_i[15:0];
        lbmc_pkg::CFG_PULSE_INTERVAL:  cfg_q.pulse_interval_ms <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  lbmc_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (in_data_i),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // mode state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode          <= lbmc_pkg::MODE_IDLE;
      st_q.fade_level    <= '0;
      st_q.fade_down     <= 1'b0;
      st_q.blink_elapsed <= '0;
      st_q.pulse_elapsed <= '0;
      st_q.pin_level     <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  // every accepted beat leaves a result waiting next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("no result after accepted beat");

  // the result reports the state that was just stored
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_data_o.led_level == st_q.pin_level) &&
               (out_data_o.mode == 3'(st_q.mode)))
    else $error("result disagrees with stored state");

  // commands never write the level
  a_command_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.op != 3'(lbmc_pkg::OP_TICK)) |=> !out_data_o.level_written)
    else $error("command wrote the level");

  // stall only when a result is held
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

// File: design/lbmc_step.sv
// Next-state and result logic for one tick or command.
module lbmc_step (
  input  lbmc_pkg::state_t st_i,
  input  lbmc_pkg::cfg_t   cfg_i,
  input  lbmc_pkg::in_t    item_i,
  output lbmc_pkg::state_t st_o,
  output lbmc_pkg::out_t   res_o
);

  localparam int unsigned EB = lbmc_pkg::ELAPSED_BITS;
  localparam int unsigned CB = lbmc_pkg::CMP_BITS;
  localparam int unsigned FB = lbmc_pkg::FADE_BITS;

  logic [EB-1:0]         blink_inc, pulse_inc;
  logic                  blink_done, pulse_due;
  logic signed [FB:0]    fade_ext, step_ext, fade_sum;
  logic signed [FB-1:0]  fade_next;
  logic signed [FB:0]    low_ext, high_ext, next_ext;
  logic [7:0]            fade_clamped;
  logic                  wrote;

  // saturating elapsed counters
  assign blink_inc = (&st_i.blink_elapsed) ? st_i.blink_elapsed : st_i.blink_elapsed + 1'b1;
  assign pulse_inc = (&st_i.pulse_elapsed) ? st_i.pulse_elapsed : st_i.pulse_elapsed + 1'b1;

  assign blink_done = CB'(blink_inc) > CB'(cfg_i.blink_interval_ms);
  assign pulse_due  = CB'(pulse_inc) > CB'(cfg_i.pulse_interval_ms);

  // fade update, saturated to the fade register range
  assign fade_ext = {st_i.fade_level[FB-1], st_i.fade_level};
  assign step_ext = signed'({{(FB+1-7){1'b0}}, cfg_i.fade_step});
  assign fade_sum = st_i.fade_down ? fade_ext - step_ext : fade_ext + step_ext;

  always_comb begin
    if (fade_sum < -(signed'((FB+1)'(1)) <<< (FB-1))) begin
      fade_next = {1'b1, {(FB-1){1'b0}}};
    end else if (fade_sum > signed'(((FB+1)'(1) << (FB-1)) - (FB+1)'(1))) begin
      fade_next = {1'b0, {(FB-1){1'b1}}};
    end else begin
      fade_next = fade_sum[FB-1:0];
    end
  end

  assign next_ext = {fade_next[FB-1], fade_next};
  assign low_ext  = signed'({{(FB+1-8){1'b0}}, cfg_i.low_brightness});
  assign high_ext = signed'({{(FB+1-8){1'b0}}, cfg_i.high_brightness});

  // level written is the old fade level, clamped to 0..255
  always_comb begin
    if (st_i.fade_level[FB-1]) begin
      fade_clamped = 8'd0;
    end else if (|st_i.fade_level[FB-2:8]) begin
      fade_clamped = 8'hFF;
    end else begin
      fade_clamped = st_i.fade_level[7:0];
    end
  end

  always_comb begin
    st_o  = st_i;
    wrote = 1'b0;
    unique case (lbmc_pkg::op_e'(item_i.op))
      lbmc_pkg::OP_TICK: begin
        st_o.blink_elapsed = blink_inc;
        st_o.pulse_elapsed = pulse_inc;
        unique case (st_i.mode)
          lbmc_pkg::MODE_ON: begin
            st_o.pin_level = cfg_i.high_brightness;
            wrote          = 1'b1;
            st_o.mode      = lbmc_pkg::MODE_IDLE;
          end
          lbmc_pkg::MODE_OFF: begin
            st_o.pin_level = 8'd0;
            wrote          = 1'b1;
            st_o.mode      = lbmc_pkg::MODE_IDLE;
          end
          lbmc_pkg::MODE_BLINK: begin
            st_o.pin_level = cfg_i.high_brightness;
            wrote          = 1'b1;
            if (blink_done) st_o.mode = lbmc_pkg::MODE_OFF;
          end
          lbmc_pkg::MODE_BLINK_PULSE: begin
            st_o.pin_level = 8'd0;
            wrote          = 1'b1;
            if (blink_done) st_o.mode = lbmc_pkg::MODE_PULSE;
          end
          lbmc_pkg::MODE_PULSE: begin
            if (pulse_due) begin
              st_o.pin_level     = fade_clamped;
              wrote              = 1'b1;
              st_o.fade_level    = fade_next;
              st_o.pulse_elapsed = '0;
              if (next_ext <= low_ext || next_ext >= high_ext) begin
                st_o.fade_down = ~st_i.fade_down;
              end
            end
          end
          default: ;
        endcase
      end
      lbmc_pkg::OP_ON:  st_o.mode = lbmc_pkg::MODE_ON;
      lbmc_pkg::OP_OFF: st_o.mode = lbmc_pkg::MODE_OFF;
      lbmc_pkg::OP_BLINK: begin
        st_o.mode          = item_i.normal ? lbmc_pkg::MODE_BLINK : lbmc_pkg::MODE_BLINK_PULSE;
        st_o.blink_elapsed = '0;
      end
      lbmc_pkg::OP_PULSE: begin
        st_o.mode = item_i.normal ? lbmc_pkg::MODE_PULSE : lbmc_pkg::MODE_OFF;
      end
      default: ;
    endcase
  end

  assign res_o.led_level     = st_o.pin_level;
  assign res_o.level_written = wrote;
  assign res_o.mode          = 3'(st_o.mode);

endmodule
